// ===== design/rmm_pkg.sv =====
package rmm_pkg;

  // Default geometry of the byte store
  localparam int unsigned REGION_BYTES_DEF = 131072;
  localparam int unsigned NUM_REGIONS_DEF  = 4;

  // Register file: one base and one size register per region slot
  localparam int unsigned REG_COUNT = 4;
  localparam int unsigned REG_IDX_W = 2;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned SIZE_W    = 18;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned APB_AW    = 5;

  // Byte lanes of the banked store
  localparam int unsigned LANES = 4;

  localparam logic [ADDR_W-1:0] BASE_RST [REG_COUNT] = '{
    32'h0000_0000, 32'h2000_0000, 32'h0000_0000, 32'h0000_0000
  };
  localparam logic [SIZE_W-1:0] SIZE_RST [REG_COUNT] = '{
    18'h2_0000, 18'h2_0000, 18'h0_0000, 18'h0_0000
  };

  // Register kind, selected by the low bit of the register index
  localparam logic REG_KIND_BASE = 1'b0;
  localparam logic REG_KIND_SIZE = 1'b1;

  // Request opcodes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Access size codes
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  // Response status
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_MISS = 1'b1;

  typedef enum logic {
    CLEARING,
    RUNNING
  } state_e;

endpackage

// ===== design/rmm_ram.sv =====
module rmm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/region_mapped_memory_top.sv =====
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+--------------------------------------
// request   | in        | in_valid_i / in_stall_o   | opcode_i, address_i, access_size_i,
//           |           |                           | write_data_i
// response  | out       | out_valid_o / out_stall_i | read_data_o, status_o
// config    | in        | APB psel/penable/pready   | paddr, pwdata, prdata
//
// One request is accepted per cycle when nothing stalls; a response passes the decode,
// store access and output registers after its request is accepted. The rate is set
// by the single access port of each byte-lane memory, used once per request.
// After reset the store is cleared one row of four bytes per cycle, over all
// NUM_REGIONS * REGION_BYTES / 4 rows (131072 with the defaults); requests stall
// meanwhile, configuration writes are taken. A stalled response backs up stage by stage.
// REGION_BYTES must be a multiple of four.
module region_mapped_memory_top #(
  parameter int unsigned REGION_BYTES = rmm_pkg::REGION_BYTES_DEF,
  parameter int unsigned NUM_REGIONS  = rmm_pkg::NUM_REGIONS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        opcode_i,
  input  logic [rmm_pkg::ADDR_W-1:0]  address_i,
  input  logic [1:0]                  access_size_i,
  input  logic [rmm_pkg::DATA_W-1:0]  write_data_i,
  // response channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rmm_pkg::DATA_W-1:0]  read_data_o,
  output logic                        status_o,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rmm_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  import rmm_pkg::*;

  // Store geometry: four byte-lane memories, one row holds four consecutive bytes
  localparam int unsigned ROWS   = REGION_BYTES / LANES;
  localparam int unsigned DEPTH  = NUM_REGIONS * ROWS;
  localparam int unsigned ROW_AW = $clog2(DEPTH);
  localparam int unsigned OFF_W  = $clog2(REGION_BYTES);
  localparam int unsigned LIM_W  = $clog2(REGION_BYTES + 1);
  localparam int unsigned CMP_W  = OFF_W + 1;

  // Clamp a programmed size to the bytes a region really owns
  function automatic logic [LIM_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
    logic [LIM_W-1:0] r;
    if (ADDR_W'(s) > ADDR_W'(REGION_BYTES)) begin
      r = LIM_W'(REGION_BYTES);
    end else begin
      r = LIM_W'(s);
    end
    return r;
  endfunction

  //--------------------------------------------------------------------------
  // Configuration registers
  //--------------------------------------------------------------------------
  logic [ADDR_W-1:0] base_q [REG_COUNT];
  logic [SIZE_W-1:0] size_q [REG_COUNT];
  logic [LIM_W-1:0]  lim_q  [REG_COUNT];   // effective size, kept alongside the raw value

  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_region;
  logic                 cfg_kind;

  assign pready     = 1'b1;
  assign cfg_we     = psel && penable && pwrite && pready;
  assign cfg_region = paddr[4:3];
  assign cfg_kind   = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < REG_COUNT; r++) begin
        base_q[r] <= BASE_RST[r];
        size_q[r] <= SIZE_RST[r];
        lim_q[r]  <= clamp_size(SIZE_RST[r]);
      end
    end else if (cfg_we) begin
      case (cfg_kind)
        REG_KIND_BASE: base_q[cfg_region] <= pwdata;
        REG_KIND_SIZE: begin
          size_q[cfg_region] <= pwdata[SIZE_W-1:0];
          lim_q[cfg_region]  <= clamp_size(pwdata[SIZE_W-1:0]);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_kind)
      REG_KIND_BASE: prdata = base_q[cfg_region];
      REG_KIND_SIZE: prdata = 32'(size_q[cfg_region]);
      default:       prdata = '0;
    endcase
  end

  //--------------------------------------------------------------------------
  // Clearing sequencer: sweep every row to zero after reset
  //--------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [ROW_AW-1:0] clr_row_q, clr_row_d;
  logic              clr_active;
  logic              clr_last;

  assign clr_last = (clr_row_q == ROW_AW'(DEPTH - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      CLEARING: if (clr_last) state_d = RUNNING;
      RUNNING:  state_d = RUNNING;
      default:  state_d = CLEARING;
    endcase
  end

  always_comb begin
    clr_active = 1'b0;
    clr_row_d  = clr_row_q;
    case (state_q)
      CLEARING: begin
        clr_active = 1'b1;
        clr_row_d  = clr_row_q + ROW_AW'(1);
      end
      RUNNING: clr_active = 1'b0;
      default: clr_active = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= CLEARING;
      clr_row_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_row_q <= clr_row_d;
    end
  end

  //--------------------------------------------------------------------------
  // Pipeline flow control: decode -> access -> output
  //--------------------------------------------------------------------------
  logic d_valid_q, d_valid_d;
  logic a_valid_q, a_valid_d;
  logic o_valid_q, o_valid_d;
  logic o_free, a_free, d_free;
  logic in_accept, d_move, a_move;

  // A stage is free when it is empty or its content moves on this edge
  assign o_free    = !o_valid_q || !out_stall_i;
  assign a_free    = !a_valid_q || o_free;
  assign d_free    = !d_valid_q || a_free;
  assign in_stall_o = clr_active || !d_free;
  assign in_accept = in_valid_i && !in_stall_o;
  assign d_move    = d_valid_q && a_free;
  assign a_move    = a_valid_q && o_free;

  always_comb begin
    d_valid_d = d_valid_q;
    a_valid_d = a_valid_q;
    o_valid_d = o_valid_q;
    if (in_accept) d_valid_d = 1'b1;
    else if (d_move) d_valid_d = 1'b0;
    if (d_move) a_valid_d = 1'b1;
    else if (a_move) a_valid_d = 1'b0;
    if (a_move) o_valid_d = 1'b1;
    else if (o_valid_q && !out_stall_i) o_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
      a_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      d_valid_q <= d_valid_d;
      a_valid_q <= a_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  //--------------------------------------------------------------------------
  // Region match on the incoming request: first enabled region wins
  //--------------------------------------------------------------------------
  logic                 hit_d;
  logic [REG_IDX_W-1:0] reg_d;
  logic [OFF_W-1:0]     off_d;
  logic [LIM_W-1:0]     lim_d;

  always_comb begin
    logic [ADDR_W-1:0] diff;
    hit_d = 1'b0;
    reg_d = '0;
    off_d = '0;
    lim_d = '0;
    // Walk from the last slot down so the lowest matching region overrides
    for (int r = REG_COUNT - 1; r >= 0; r--) begin
      diff = address_i - base_q[r];
      if ((r < NUM_REGIONS) && (diff < ADDR_W'(lim_q[r]))) begin
        hit_d = 1'b1;
        reg_d = REG_IDX_W'(r);
        off_d = OFF_W'(diff);
        lim_d = lim_q[r];
      end
    end
  end

  logic                 d_op_q;
  logic                 d_hit_q;
  logic [1:0]           d_size_q;
  logic [DATA_W-1:0]    d_wdata_q;
  logic [REG_IDX_W-1:0] d_reg_q;
  logic [OFF_W-1:0]     d_off_q;
  logic [LIM_W-1:0]     d_lim_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      d_op_q    <= opcode_i;
      d_hit_q   <= hit_d;
      d_size_q  <= access_size_i;
      d_wdata_q <= write_data_i;
      d_reg_q   <= reg_d;
      d_off_q   <= off_d;
      d_lim_q   <= lim_d;
    end
  end

  //--------------------------------------------------------------------------
  // Lane steering: byte i of the request lands in lane (offset + i) mod 4.
  // Lanes below the start lane take the next row.
  //--------------------------------------------------------------------------
  logic [2:0]        nbytes;
  logic [LANES-1:0]  lane_en;
  logic [ROW_AW-1:0] lane_addr  [LANES];
  logic [7:0]        lane_wdata [LANES];
  logic [ROW_AW-1:0] row_base;

  always_comb begin
    case (d_size_q)
      SZ_BYTE: nbytes = 3'd1;
      SZ_HALF: nbytes = 3'd2;
      SZ_WORD: nbytes = 3'd4;
      default: nbytes = 3'd0;
    endcase
  end

  assign row_base = ROW_AW'(d_reg_q * ROWS) + ROW_AW'(d_off_q[OFF_W-1:2]);

  always_comb begin
    logic [1:0]       idx;
    logic [CMP_W-1:0] boff;
    for (int l = 0; l < LANES; l++) begin
      idx  = 2'(l) - d_off_q[1:0];
      boff = CMP_W'(d_off_q) + CMP_W'(idx);
      // Drop bytes beyond the access size or past the region end
      lane_en[l]    = d_hit_q && ({1'b0, idx} < nbytes) && (boff < CMP_W'(d_lim_q));
      lane_addr[l]  = '0;
      lane_wdata[l] = d_wdata_q[{idx, 3'b000} +: 8];
      if (lane_en[l]) begin
        lane_addr[l] = row_base + ROW_AW'(2'(l) < d_off_q[1:0]);
      end
    end
  end

  //--------------------------------------------------------------------------
  // Byte-lane memories
  //--------------------------------------------------------------------------
  logic [7:0] ram_rdata [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic              ram_en;
    logic              ram_we;
    logic [ROW_AW-1:0] ram_addr;
    logic [7:0]        ram_wdata;

    always_comb begin
      if (clr_active) begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_row_q;
        ram_wdata = '0;
      end else begin
        ram_en    = d_move && lane_en[l];
        ram_we    = (d_op_q == OP_WRITE);
        ram_addr  = lane_addr[l];
        ram_wdata = lane_wdata[l];
      end
    end

    rmm_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .en_i    (ram_en),
      .we_i    (ram_we),
      .addr_i  (ram_addr),
      .wdata_i (ram_wdata),
      .rdata_o (ram_rdata[l])
    );
  end

  //--------------------------------------------------------------------------
  // Access stage: read data arrives from the lanes, realign to byte order
  //--------------------------------------------------------------------------
  logic             a_hit_q;
  logic [1:0]       a_shift_q;
  logic [LANES-1:0] a_ren_q;

  always_ff @(posedge clk_i) begin
    if (d_move) begin
      a_hit_q   <= d_hit_q;
      a_shift_q <= d_off_q[1:0];
      // Only lanes that were read contribute; writes and misses return zero
      a_ren_q   <= (d_op_q == OP_READ) ? lane_en : '0;
    end
  end

  logic [DATA_W-1:0] rdata_d;

  always_comb begin
    logic [1:0] lane;
    for (int i = 0; i < LANES; i++) begin
      lane = 2'(i) + a_shift_q;
      rdata_d[8*i +: 8] = a_ren_q[lane] ? ram_rdata[lane] : 8'h00;
    end
  end

  //--------------------------------------------------------------------------
  // Output register
  //--------------------------------------------------------------------------
  logic [DATA_W-1:0] o_rdata_q;
  logic              o_status_q;

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      o_rdata_q  <= rdata_d;
      o_status_q <= a_hit_q ? ST_OK : ST_MISS;
    end
  end

  assign out_valid_o = o_valid_q;
  assign read_data_o = o_rdata_q;
  assign status_o    = o_status_q;

endmodule
